FILE: rtl/ph_tm_pkg.sv
package ph_tm_pkg;

  localparam int ADC_W          = 10;
  localparam int MV_W           = 13;
  localparam int PH_W           = 17;
  localparam int OFS_W          = 16;
  localparam int APB_DW         = 32;
  localparam int PADDR_W        = 3;
  localparam int WINDOW_DEFAULT = 40;
  localparam int ADC_MAX        = 1023;
  localparam int MV_SCALE       = 5000;
  localparam int SCALE_SHIFT    = 10;
  localparam int MV_MAX         = 4996;

  localparam logic [PADDR_W-3:0] REG_PH_OFFSET = '0;

  typedef struct packed {
    logic clear;
    logic en;
  } ph_tm_acc_ctl_t;

endpackage

FILE: rtl/ph_sensor_trimmed_mean_top.sv
// pH sensor front end: trimmed moving average of 10-bit converter samples.
//
// Input channel: adc_sample with in_valid / in_stall. A beat is taken when
// in_valid is high and in_stall is low. Output channel: voltage_mv and
// ph_milli with out_valid / out_stall, held steady while out_stall is high.
// Configuration: APB-style write of ph_offset_milli at byte address 0.
//
// Each sample enters a chain of WINDOW cells; the chain then rotates once
// through all cells while an accumulator gathers sum, minimum and maximum,
// one cell per cycle. The division by the constant count of kept samples
// (WINDOW - 2 when the minimum and maximum are trimmed, else WINDOW) is a
// reciprocal multiplication: the numerator is registered, then the quotient.
// A new input beat is taken only in the idle state, once the previous result
// has moved on to the output register; until then in_stall stays high.
//
// While a result waits under out_stall the next sample is still taken and
// processed; it waits in the final step until the output register frees.
// Synchronous reset clears all window cells to zero, the offset to zero and
// drops any pending result.
module ph_sensor_trimmed_mean_top #(
  parameter int WINDOW = ph_tm_pkg::WINDOW_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ph_tm_pkg::ADC_W-1:0]         adc_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ph_tm_pkg::MV_W-1:0]          voltage_mv,
  output logic signed [ph_tm_pkg::PH_W-1:0]   ph_milli,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ph_tm_pkg::PADDR_W-1:0]       paddr,
  input  logic [ph_tm_pkg::APB_DW-1:0]        pwdata,
  output logic [ph_tm_pkg::APB_DW-1:0]        prdata,
  output logic                                pready
);
  import ph_tm_pkg::*;

  localparam bit TRIM    = (WINDOW >= 5);
  localparam int DIVISOR = TRIM ? (WINDOW - 2) : WINDOW;
  localparam int SUM_W   = $clog2(ADC_MAX * WINDOW + 1);
  localparam int PROD_W  = SUM_W + MV_W;
  localparam int NUM_W   = PROD_W - SCALE_SHIFT;
  localparam int CNT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW - 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SCAN = 6'b000010,
    ST_LOAD = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_POST = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [CNT_W-1:0]          cnt;
  logic signed [OFS_W-1:0]   ph_offset_milli;
  logic [MV_W-1:0]           mv;

  logic                      in_take;
  logic                      out_take;
  logic                      out_load;
  logic                      shift;
  logic [ADC_W-1:0]          chain_in;
  logic [ADC_W-1:0]          cell_q [WINDOW];
  logic [ADC_W-1:0]          tail;
  ph_tm_acc_ctl_t            acc_ctl;
  logic [SUM_W-1:0]          sum;
  logic [ADC_W-1:0]          lo;
  logic [ADC_W-1:0]          hi;
  logic [SUM_W-1:0]          s_val;
  logic [PROD_W-1:0]         prod;
  logic [NUM_W-1:0]          num;
  logic                      div_start;
  logic                      div_done;
  logic [MV_W-1:0]           quot;
  logic [2*MV_W-1:0]         pprod;
  logic [MV_W+2:0]           mv_x7;
  logic signed [PH_W-1:0]    ph_val;
  logic [PADDR_W-3:0]        reg_idx;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  assign shift    = in_take || (state == ST_SCAN);
  assign tail     = cell_q[WINDOW-1];
  assign chain_in = in_take ? adc_sample : tail;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      ph_tm_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (chain_in),
        .q     (cell_q[i])
      );
    end else begin : g_body
      ph_tm_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (cell_q[i-1]),
        .q     (cell_q[i])
      );
    end
  end

  assign acc_ctl.clear = in_take;
  assign acc_ctl.en    = (state == ST_SCAN);

  ph_tm_acc #(
    .SUM_W (SUM_W)
  ) u_acc (
    .clk (clk),
    .ctl (acc_ctl),
    .din (tail),
    .sum (sum),
    .lo  (lo),
    .hi  (hi)
  );

  assign s_val = TRIM ? (sum - SUM_W'(lo) - SUM_W'(hi)) : sum;
  assign prod  = PROD_W'(s_val) * PROD_W'(MV_SCALE);
  assign num   = TRIM ? prod[PROD_W-1:SCALE_SHIFT] : NUM_W'(sum);
  assign div_start = (state == ST_LOAD);

  ph_tm_div #(
    .NUM_W   (NUM_W),
    .DIVISOR (DIVISOR)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .done  (div_done),
    .quot  (quot)
  );

  assign pprod  = (2*MV_W)'(quot) * (2*MV_W)'(MV_SCALE);
  assign mv_x7  = {mv, 3'b000} - {3'b000, mv};
  assign ph_val = $signed({2'b00, mv_x7[MV_W+2:1]})
                + $signed({ph_offset_milli[OFS_W-1], ph_offset_milli});

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_take) state_next = ST_SCAN;
      ST_SCAN: if (cnt == CNT_LAST) state_next = ST_LOAD;
      ST_LOAD: state_next = ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_POST;
      ST_POST: state_next = ST_DONE;
      ST_DONE: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cnt <= '0;
    end else if (state == ST_SCAN) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_POST) begin
      mv <= TRIM ? quot : pprod[SCALE_SHIFT +: MV_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      voltage_mv <= mv;
      ph_milli   <= ph_val;
    end
  end

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      ph_offset_milli <= '0;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_PH_OFFSET) begin
      ph_offset_milli <= pwdata[OFS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_PH_OFFSET) begin
      prdata = {{(APB_DW-OFS_W){1'b0}}, ph_offset_milli};
    end
  end

endmodule

FILE: rtl/ph_tm_cell.sv
module ph_tm_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       shift,
  input  logic [ph_tm_pkg::ADC_W-1:0] d,
  output logic [ph_tm_pkg::ADC_W-1:0] q
);
  import ph_tm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

FILE: rtl/ph_tm_acc.sv
module ph_tm_acc #(
  parameter int SUM_W = 16
) (
  input  logic                        clk,
  input  ph_tm_pkg::ph_tm_acc_ctl_t   ctl,
  input  logic [ph_tm_pkg::ADC_W-1:0] din,
  output logic [SUM_W-1:0]            sum,
  output logic [ph_tm_pkg::ADC_W-1:0] lo,
  output logic [ph_tm_pkg::ADC_W-1:0] hi
);
  import ph_tm_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sum <= '0;
      lo  <= ADC_W'(ADC_MAX);
      hi  <= '0;
    end else if (ctl.en) begin
      sum <= sum + SUM_W'(din);
      if (din < lo) begin
        lo <= din;
      end
      if (din > hi) begin
        hi <= din;
      end
    end
  end

endmodule

FILE: rtl/ph_tm_div.sv
module ph_tm_div #(
  parameter int NUM_W   = 19,
  parameter int DIVISOR = 38
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [NUM_W-1:0]           num,
  output logic                       done,
  output logic [ph_tm_pkg::MV_W-1:0] quot
);
  import ph_tm_pkg::*;

  localparam int L_W   = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
  localparam int K     = NUM_W + L_W;
  localparam int M_W   = NUM_W + 2;
  localparam int P_W   = NUM_W + M_W;
  localparam logic [M_W-1:0] RECIP =
    M_W'(((64'd1 << K) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [NUM_W-1:0] nreg;
  logic [P_W-1:0]   qprod;
  logic             busy;

  assign qprod = P_W'(nreg) * P_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nreg <= num;
    end
    if (busy) begin
      quot <= qprod[K +: MV_W];
    end
  end

endmodule

FILE: rtl/ph_tm_check.sv
module ph_tm_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [ph_tm_pkg::ADC_W-1:0]       adc_sample,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [ph_tm_pkg::MV_W-1:0]        voltage_mv,
  input logic signed [ph_tm_pkg::PH_W-1:0] ph_milli,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [ph_tm_pkg::PADDR_W-1:0]     paddr,
  input logic [ph_tm_pkg::APB_DW-1:0]      pwdata,
  input logic [ph_tm_pkg::APB_DW-1:0]      prdata,
  input logic                              pready
);
  import ph_tm_pkg::*;

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous sample still in work");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result appeared right after input beat");

  a_mv_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (voltage_mv <= MV_W'(MV_MAX)))
    else $error("voltage out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(voltage_mv) && $stable(ph_milli)))
    else $error("stalled result beat changed");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind ph_sensor_trimmed_mean_top ph_tm_check u_check (.*);
